@@ src/nkls_pkg.sv @@
// Shared types and constants for the nearest-light selector.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package nkls_pkg;

    localparam int RADIUS_W     = 16;
    localparam int SLOT_INDEX_W = 2;
    localparam int COUNT_W      = 3;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_CAMERA_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAMERA_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAMERA_Z = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_INSERT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic square;
        logic sum;
        logic insert;
        logic emit;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic end_mark;
        logic emit_last;
        logic out_free;
    } sts_t;

endpackage

@@ src/nearest_k_light_selector.sv @@
// Top level of the nearest-light selector: stream ports and field packing.
// Instantiates nkls_ctrl and nkls_datapath; depends on nkls_pkg.
//
// Usage: write camera_x/y/z through cfg_we/cfg_index/cfg_data (index 0..2,
// others ignored) while the block is idle. Light items arrive on the s_*
// stream; s_tlast marks the final light of a list. Each usable light (point
// flag set, nonzero radius) is ranked by squared distance to the camera and
// kept in one of SLOTS sorted entries, ties keeping the earlier light ahead.
// Each item is handled in order: accept with distance deltas, square (one
// multiplier per axis), sum, then a parallel compare against all entries
// that inserts in place. s_tready is high only between items.
// After a list's last item the block sends SLOTS results on m_*, rank 0
// first, m_tlast on the final one; the first is loaded after that item is
// inserted, then one per cycle while m_tready is high. A stalled receiver
// holds the output register and the emission sequence waits; once the last
// result is loaded the selection clears and a new item can be accepted.
// Reset clears the camera registers, the selection and the output valid.
`timescale 1ns / 1ps

module nearest_k_light_selector #(
    parameter int SLOTS      = 4,
    parameter int COORD_BITS = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [nkls_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [COORD_BITS-1:0]                  cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // light_x, light_y, light_z, light_radius, zero fill
    input  logic [((3*COORD_BITS+16+7)/8)*8-1:0]   s_tdata,
    // is_point_light
    input  logic                                   s_tuser,
    input  logic                                   s_tlast,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // slot_index, pos_x, pos_y, pos_z, radius_out, light_count, zero fill
    output logic [((3*COORD_BITS+21+7)/8)*8-1:0]   m_tdata,
    // slot_valid
    output logic                                   m_tuser,
    output logic                                   m_tlast
);
    import nkls_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int IN_W   = ((3 * CB + 16 + 7) / 8) * 8;
    localparam int OUT_W  = ((3 * CB + 21 + 7) / 8) * 8;
    localparam int IN_USE = 3 * CB + RADIUS_W;
    localparam int OUT_USE = SLOT_INDEX_W + 3 * CB + RADIUS_W + COUNT_W;
    localparam int CNT_LO = SLOT_INDEX_W + 3 * CB + RADIUS_W;

    cmd_t cmd;
    sts_t sts;

    logic [SLOT_INDEX_W-1:0] slot_index;
    logic [CB-1:0]           pos_x;
    logic [CB-1:0]           pos_y;
    logic [CB-1:0]           pos_z;
    logic [RADIUS_W-1:0]     radius_out;
    logic [COUNT_W-1:0]      light_count;
    logic [IN_W-1:0]         in_data;

    assign in_data = s_tdata;

    nkls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nkls_datapath #(
        .SLOTS      (SLOTS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .light_x        (in_data[CB-1:0]),
        .light_y        (in_data[2*CB-1:CB]),
        .light_z        (in_data[3*CB-1:2*CB]),
        .light_radius   (in_data[IN_USE-1:3*CB]),
        .is_point_light (s_tuser),
        .end_of_list    (s_tlast),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .slot_index     (slot_index),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .radius_out     (radius_out),
        .slot_valid     (m_tuser),
        .light_count    (light_count),
        .last_slot      (m_tlast)
    );

    assign m_tdata = OUT_W'({light_count, radius_out, pos_z, pos_y, pos_x, slot_index});

    property p_one_item_at_a_time;
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready;
    endproperty
    a_one_item_at_a_time: assert property (p_one_item_at_a_time)
        else $error("input accepted on consecutive cycles");

    property p_last_is_final_rank;
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[SLOT_INDEX_W-1:0] == SLOT_INDEX_W'(SLOTS - 1));
    endproperty
    a_last_is_final_rank: assert property (p_last_is_final_rank)
        else $error("end of run flagged on a rank other than the final one");

    property p_valid_below_count;
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser && (SLOTS <= 4))
            |-> (COUNT_W'(m_tdata[SLOT_INDEX_W-1:0]) < m_tdata[CNT_LO +: COUNT_W]);
    endproperty
    a_valid_below_count: assert property (p_valid_below_count)
        else $error("occupied slot reported at or beyond the light count");

    property p_no_item_while_emitting;
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> !s_tready;
    endproperty
    a_no_item_while_emitting: assert property (p_no_item_while_emitting)
        else $error("input ready while a run of results is still being sent");

    if (OUT_USE > OUT_W)
    begin : g_width_check
        assign m_tdata[0] = 1'b0;
    end

endmodule

@@ src/nkls_ctrl.sv @@
// Sequencing state machine of the nearest-light selector.
// Drives datapath commands from datapath status; depends on nkls_pkg.
`timescale 1ns / 1ps

module nkls_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  nkls_pkg::sts_t sts,
    output nkls_pkg::cmd_t cmd
);
    import nkls_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = sts.end_mark ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.emit_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/nkls_datapath.sv @@
// Datapath of the nearest-light selector: camera registers, distance
// pipeline, sorted slot table and result register. Depends on nkls_pkg.
`timescale 1ns / 1ps

module nkls_datapath #(
    parameter int SLOTS      = 4,
    parameter int COORD_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  nkls_pkg::cmd_t                       cmd,
    output nkls_pkg::sts_t                       sts,
    input  logic                                 cfg_we,
    input  logic [nkls_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [COORD_BITS-1:0]                cfg_data,
    input  logic [COORD_BITS-1:0]                light_x,
    input  logic [COORD_BITS-1:0]                light_y,
    input  logic [COORD_BITS-1:0]                light_z,
    input  logic [nkls_pkg::RADIUS_W-1:0]        light_radius,
    input  logic                                 is_point_light,
    input  logic                                 end_of_list,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [nkls_pkg::SLOT_INDEX_W-1:0]    slot_index,
    output logic [COORD_BITS-1:0]                pos_x,
    output logic [COORD_BITS-1:0]                pos_y,
    output logic [COORD_BITS-1:0]                pos_z,
    output logic [nkls_pkg::RADIUS_W-1:0]        radius_out,
    output logic                                 slot_valid,
    output logic [nkls_pkg::COUNT_W-1:0]         light_count,
    output logic                                 last_slot
);
    import nkls_pkg::*;

    localparam int CW   = $clog2(SLOTS + 1);
    localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MW   = 2 * COORD_BITS;
    localparam int DW   = 2 * COORD_BITS + 2;

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic [COORD_BITS:0] d;
        logic [COORD_BITS:0] m;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        m = d[COORD_BITS] ? (~d + 1'b1) : d;
        return m[COORD_BITS-1:0];
    endfunction

    logic [COORD_BITS-1:0] cam_x_reg;
    logic [COORD_BITS-1:0] cam_y_reg;
    logic [COORD_BITS-1:0] cam_z_reg;

    logic [COORD_BITS-1:0] item_x_reg;
    logic [COORD_BITS-1:0] item_y_reg;
    logic [COORD_BITS-1:0] item_z_reg;
    logic [RADIUS_W-1:0]   item_r_reg;
    logic                  usable_reg;
    logic                  end_reg;
    logic [COORD_BITS-1:0] mag_x_reg;
    logic [COORD_BITS-1:0] mag_y_reg;
    logic [COORD_BITS-1:0] mag_z_reg;
    logic [MW-1:0]         sq_x_reg;
    logic [MW-1:0]         sq_y_reg;
    logic [MW-1:0]         sq_z_reg;
    logic [DW-1:0]         dist_reg;

    logic [DW-1:0]         slot_dist_reg [SLOTS];
    logic [COORD_BITS-1:0] slot_x_reg    [SLOTS];
    logic [COORD_BITS-1:0] slot_y_reg    [SLOTS];
    logic [COORD_BITS-1:0] slot_z_reg    [SLOTS];
    logic [RADIUS_W-1:0]   slot_r_reg    [SLOTS];
    logic [CW-1:0]         count_reg;
    logic [IDXW-1:0]       emit_idx_reg;

    logic                  out_valid_reg;
    logic [SLOT_INDEX_W-1:0] out_index_reg;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic [COORD_BITS-1:0] out_z_reg;
    logic [RADIUS_W-1:0]   out_r_reg;
    logic                  out_slot_valid_reg;
    logic [COUNT_W-1:0]    out_count_reg;
    logic                  out_last_reg;

    logic [SLOTS-1:0]      less;
    logic                  full;
    logic                  go;
    logic                  emit_last;
    logic                  emit_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CAMERA_X: cam_x_reg <= cfg_data;
                CFG_CAMERA_Y: cam_y_reg <= cfg_data;
                CFG_CAMERA_Z: cam_z_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_x_reg <= light_x;
            item_y_reg <= light_y;
            item_z_reg <= light_z;
            item_r_reg <= light_radius;
            usable_reg <= is_point_light && (light_radius != '0);
            end_reg    <= end_of_list;
            mag_x_reg  <= abs_diff(light_x, cam_x_reg);
            mag_y_reg  <= abs_diff(light_y, cam_y_reg);
            mag_z_reg  <= abs_diff(light_z, cam_z_reg);
        end
        if (cmd.square)
        begin
            sq_x_reg <= MW'(mag_x_reg) * MW'(mag_x_reg);
            sq_y_reg <= MW'(mag_y_reg) * MW'(mag_y_reg);
            sq_z_reg <= MW'(mag_z_reg) * MW'(mag_z_reg);
        end
        if (cmd.sum)
        begin
            dist_reg <= DW'(sq_x_reg) + DW'(sq_y_reg) + DW'(sq_z_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            less[i] = (CW'(i) < count_reg) && (dist_reg < slot_dist_reg[i]);
        end
    end

    assign full = (count_reg == CW'(SLOTS));
    assign go   = usable_reg && (!full || less[SLOTS-1]);

    always_ff @(posedge clk)
    begin
        if (cmd.insert && go)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (less[i] || (CW'(i) == count_reg))
                begin
                    if ((i > 0) && less[(i > 0) ? i - 1 : 0])
                    begin
                        slot_dist_reg[i] <= slot_dist_reg[(i > 0) ? i - 1 : 0];
                        slot_x_reg[i]    <= slot_x_reg[(i > 0) ? i - 1 : 0];
                        slot_y_reg[i]    <= slot_y_reg[(i > 0) ? i - 1 : 0];
                        slot_z_reg[i]    <= slot_z_reg[(i > 0) ? i - 1 : 0];
                        slot_r_reg[i]    <= slot_r_reg[(i > 0) ? i - 1 : 0];
                    end
                    else
                    begin
                        slot_dist_reg[i] <= dist_reg;
                        slot_x_reg[i]    <= item_x_reg;
                        slot_y_reg[i]    <= item_y_reg;
                        slot_z_reg[i]    <= item_z_reg;
                        slot_r_reg[i]    <= item_r_reg;
                    end
                end
            end
        end
    end

    assign emit_last  = (emit_idx_reg == IDXW'(SLOTS - 1));
    assign emit_valid = (CW'(emit_idx_reg) < count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            emit_idx_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.insert && go && !full)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.emit)
            begin
                emit_idx_reg <= emit_last ? '0 : emit_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_index_reg      <= SLOT_INDEX_W'(emit_idx_reg);
            out_x_reg          <= emit_valid ? slot_x_reg[emit_idx_reg] : '0;
            out_y_reg          <= emit_valid ? slot_y_reg[emit_idx_reg] : '0;
            out_z_reg          <= emit_valid ? slot_z_reg[emit_idx_reg] : '0;
            out_r_reg          <= emit_valid ? slot_r_reg[emit_idx_reg] : '0;
            out_slot_valid_reg <= emit_valid;
            out_count_reg      <= COUNT_W'(count_reg);
            out_last_reg       <= emit_last;
        end
    end

    assign sts.end_mark  = end_reg;
    assign sts.emit_last = emit_last;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign slot_index  = out_index_reg;
    assign pos_x       = out_x_reg;
    assign pos_y       = out_y_reg;
    assign pos_z       = out_z_reg;
    assign radius_out  = out_r_reg;
    assign slot_valid  = out_slot_valid_reg;
    assign light_count = out_count_reg;
    assign last_slot   = out_last_reg;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for nearest_k_light_selector: directed and random light lists,
// camera register writes, random idling on both streams and a long receiver hold-off.
// Depends on nkls_pkg and the nearest_k_light_selector RTL.
`timescale 1ns / 1ps

module tb;
    import nkls_pkg::*;

    localparam int SLOTS         = 4;
    localparam int COORD_W       = 24;
    localparam int S_DATA_W      = ((3*COORD_W+16+7)/8)*8;
    localparam int M_DATA_W      = ((3*COORD_W+21+7)/8)*8;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_LEN      = 120;
    localparam int STALL_LIMIT   = 4000;
    localparam int REPORT_CAP    = 40;
    localparam int ITEM_TARGET   = 310;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [COORD_W-1:0] COORD_MIN = 24'h800000;
    localparam logic [COORD_W-1:0] COORD_MAX = 24'h7FFFFF;

    typedef struct {
        logic [SLOT_INDEX_W-1:0] rank;
        logic [COORD_W-1:0]      x;
        logic [COORD_W-1:0]      y;
        logic [COORD_W-1:0]      z;
        logic [RADIUS_W-1:0]     radius;
        logic                    valid;
        logic [COUNT_W-1:0]      count;
        logic                    last;
    } slot_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0]     cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    // camera registers and held selection as the block should see them
    logic [COORD_W-1:0]  cam_x = '0;
    logic [COORD_W-1:0]  cam_y = '0;
    logic [COORD_W-1:0]  cam_z = '0;
    longint unsigned     held_dist [SLOTS];
    logic [COORD_W-1:0]  held_x [SLOTS];
    logic [COORD_W-1:0]  held_y [SLOTS];
    logic [COORD_W-1:0]  held_z [SLOTS];
    logic [RADIUS_W-1:0] held_r [SLOTS];
    int                  held_n = 0;

    slot_result_t pending_slots[$];

    int mismatches  = 0;
    int items_sent  = 0;
    bit idle_en     = 1'b1;
    int hold_ticket = 0;

    nearest_k_light_selector #(
        .SLOTS      (SLOTS),
        .COORD_BITS (COORD_W)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        if (!idle_en)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(12, 4);
        return $urandom_range(50, 20);
    endfunction

    function automatic longint unsigned axis_sq(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
        longint          d;
        longint unsigned u;
        d = longint'($signed(a)) - longint'($signed(b));
        if (d < 0)
            d = -d;
        u = d;
        return u * u;
    endfunction

    function automatic void clear_selection();
        for (int k = 0; k < SLOTS; k++)
        begin
            held_dist[k] = 0;
            held_x[k]    = '0;
            held_y[k]    = '0;
            held_z[k]    = '0;
            held_r[k]    = '0;
        end
        held_n = 0;
    endfunction

    function automatic void rank_light(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                       logic [COORD_W-1:0] z, logic [RADIUS_W-1:0] r);
        longint unsigned dist_sq;
        int              pos;
        dist_sq = axis_sq(x, cam_x) + axis_sq(y, cam_y) + axis_sq(z, cam_z);
        if (held_n < SLOTS)
        begin
            pos = held_n;
            held_n++;
        end
        else
        begin
            pos = SLOTS - 1;
            if (dist_sq >= held_dist[pos])
                return;
        end
        while (pos > 0 && dist_sq < held_dist[pos-1])
        begin
            held_dist[pos] = held_dist[pos-1];
            held_x[pos]    = held_x[pos-1];
            held_y[pos]    = held_y[pos-1];
            held_z[pos]    = held_z[pos-1];
            held_r[pos]    = held_r[pos-1];
            pos--;
        end
        held_dist[pos] = dist_sq;
        held_x[pos]    = x;
        held_y[pos]    = y;
        held_z[pos]    = z;
        held_r[pos]    = r;
    endfunction

    function automatic void emit_selection();
        slot_result_t res;
        for (int k = 0; k < SLOTS; k++)
        begin
            res.valid  = (k < held_n);
            res.rank   = k[SLOT_INDEX_W-1:0];
            res.x      = res.valid ? held_x[k] : '0;
            res.y      = res.valid ? held_y[k] : '0;
            res.z      = res.valid ? held_z[k] : '0;
            res.radius = res.valid ? held_r[k] : '0;
            res.count  = held_n[COUNT_W-1:0];
            res.last   = (k == SLOTS - 1);
            pending_slots = {pending_slots, res};
        end
        clear_selection();
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < REPORT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    task automatic check_slot();
        slot_result_t want;
        if (pending_slots.size() == 0)
        begin
            report_mismatch("result transaction with no expected result");
            return;
        end
        want = pending_slots.pop_front();
        check_field("slot_index",  32'(m_tdata[1:0]),   32'(want.rank));
        check_field("pos_x",       32'(m_tdata[25:2]),  32'(want.x));
        check_field("pos_y",       32'(m_tdata[49:26]), 32'(want.y));
        check_field("pos_z",       32'(m_tdata[73:50]), 32'(want.z));
        check_field("radius_out",  32'(m_tdata[89:74]), 32'(want.radius));
        check_field("light_count", 32'(m_tdata[92:90]), 32'(want.count));
        check_field("slot_valid",  32'(m_tuser),        32'(want.valid));
        check_field("last_slot",   32'(m_tlast),        32'(want.last));
    endtask

    initial
    begin : result_checker
        int hold_served;
        int hold_left;
        int gap_left;
        hold_served = 0;
        hold_left   = 0;
        gap_left    = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_slot();
            if (hold_ticket != hold_served)
            begin
                hold_served = hold_ticket;
                hold_left   = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                gap_left = pick_gap();
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** nearest_k_light_selector: FAILED **");
        $finish;
    end

    task automatic send_light(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [COORD_W-1:0] z, input logic [RADIUS_W-1:0] r,
                              input logic point, input logic eol);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, z, y, x};
        s_tuser  <= point;
        s_tlast  <= eol;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (point && r != 0)
            rank_light(x, y, z, r);
        if (eol)
            emit_selection();
    endtask

    task automatic send_random_light(input logic eol);
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  z;
        logic [RADIUS_W-1:0] r;
        logic                point;
        int                  roll;
        if ($urandom_range(99) < 40)
        begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
            z = COORD_W'($urandom);
        end
        else
        begin
            // near the camera so that ties and displacement happen often
            x = cam_x + COORD_W'(int'($urandom_range(8)) - 4);
            y = cam_y + COORD_W'(int'($urandom_range(8)) - 4);
            z = cam_z + COORD_W'(int'($urandom_range(8)) - 4);
        end
        roll = $urandom_range(99);
        if (roll < 10)
            r = '0;
        else if (roll < 20)
            r = '1;
        else
            r = RADIUS_W'($urandom);
        point = ($urandom_range(99) < 85);
        send_light(x, y, z, r, point, eol);
    endtask

    // drop valid and wait for the selection to drain out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_slots.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_camera(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [COORD_W-1:0] z, input bit poke_unused);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CAMERA_X;
        cfg_data  <= x;
        @(posedge clk);
        cfg_index <= CFG_CAMERA_Y;
        cfg_data  <= y;
        @(posedge clk);
        cfg_index <= CFG_CAMERA_Z;
        cfg_data  <= z;
        @(posedge clk);
        if (poke_unused)
        begin
            cfg_index <= CFG_UNUSED;
            cfg_data  <= COORD_W'($urandom);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cam_x = x;
        cam_y = y;
        cam_z = z;
    endtask

    task automatic test_empty_lists();
        send_light(24'h000123, 24'h000456, 24'h000789, 16'd5, 1'b0, 1'b1);
        send_light(24'h000010, 24'h000020, 24'h000030, 16'd0, 1'b1, 1'b1);
        wait_idle();
    endtask

    task automatic test_ties_and_extremes();
        set_camera(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
        send_light(COORD_MAX, COORD_MIN, COORD_MAX, 16'hFFFF, 1'b1, 1'b0);
        send_light(COORD_MIN, COORD_MAX, COORD_MIN, 16'd1, 1'b1, 1'b0);
        send_light(COORD_MIN + 24'd3, COORD_MAX, COORD_MIN, 16'h8000, 1'b1, 1'b0);
        send_light(COORD_MIN, COORD_MAX - 24'd3, COORD_MIN, 16'd2, 1'b1, 1'b0);
        send_light(COORD_MIN, COORD_MAX, COORD_MIN + 24'd3, 16'd3, 1'b1, 1'b0);
        send_light(COORD_MIN + 24'd3, COORD_MAX, COORD_MIN, 16'd4, 1'b1, 1'b0);
        send_light(COORD_MIN, COORD_MAX, COORD_MIN, 16'd9, 1'b0, 1'b0);
        send_light(COORD_MIN + 24'd1, COORD_MAX, COORD_MIN, 16'h7FFF, 1'b1, 1'b1);
        wait_idle();
    endtask

    task automatic test_far_corner();
        set_camera(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        send_light(COORD_MIN, COORD_MIN, COORD_MIN, 16'hFFFF, 1'b1, 1'b0);
        send_light(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), 16'd7,
                   1'b1, 1'b1);
        wait_idle();
        set_camera('0, '0, '0, 1'b0);
        send_light('0, '0, '0, 16'hFFFF, 1'b1, 1'b1);
        wait_idle();
    endtask

    task automatic test_receiver_holdoff();
        int len;
        idle_en = 1'b0;
        hold_ticket++;
        for (int l = 0; l < 5; l++)
        begin
            len = $urandom_range(3, 1);
            for (int i = 0; i < len; i++)
                send_random_light(i == len - 1);
        end
        wait_idle();
        idle_en = 1'b1;
    endtask

    task automatic test_random_lists();
        int batch;
        int len;
        int roll;
        batch = 0;
        while (items_sent < ITEM_TARGET)
        begin
            batch++;
            idle_en = (batch % 4 != 0);
            case (batch % 5)
                0: set_camera(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                              1'b0);
                1: set_camera(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
                2: set_camera(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
                3: set_camera($urandom_range(1) ? COORD_MIN : COORD_MAX,
                              $urandom_range(1) ? COORD_MIN : COORD_MAX,
                              $urandom_range(1) ? COORD_MIN : COORD_MAX, 1'b0);
                default: ;
            endcase
            for (int l = 0; l < 3; l++)
            begin
                roll = $urandom_range(99);
                if (roll < 70)
                    len = $urandom_range(8, 1);
                else if (roll < 90)
                    len = $urandom_range(16, 9);
                else
                    len = 1;
                for (int i = 0; i < len; i++)
                    send_random_light(i == len - 1);
            end
            wait_idle();
        end
        idle_en = 1'b1;
    endtask

    initial
    begin
        clear_selection();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_lists();
        test_ties_and_extremes();
        test_far_corner();
        test_receiver_holdoff();
        test_random_lists();
        test_receiver_holdoff();

        wait_idle();
        if (mismatches == 0)
            $display("** nearest_k_light_selector: PASSED **");
        else
            $display("** nearest_k_light_selector: FAILED **");
        $finish;
    end

endmodule
